// ===== rtl/core/tetl_pkg.sv =====
// shared constants, codes and types for the timed event table lookup core
`timescale 1ns / 1ps
`default_nettype none
package tetl_pkg;

  localparam int MAX_EVENTS = 256;
  localparam int IDX_W      = $clog2(MAX_EVENTS);
  localparam int CNT_W      = 9;
  localparam int FRAME_W    = 32;
  localparam int PAD_W      = 8;

  typedef logic [1:0]         op_t;
  typedef logic [1:0]         status_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [PAD_W-1:0]   pad_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [IDX_W-1:0]   idx_t;

  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_APPEND = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_ORDER = 2'd2;

  typedef struct packed {
    frame_t frame;
    pad_t   one;
    pad_t   two;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/tetl_if.sv =====
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface tetl_req_if;
  import tetl_pkg::*;
  logic   valid;
  logic   ready;
  op_t    operation;
  frame_t frame_number;
  pad_t   pad_one;
  pad_t   pad_two;
  modport source (output valid, operation, frame_number, pad_one, pad_two, input ready);
  modport sink (input valid, operation, frame_number, pad_one, pad_two, output ready);
endinterface

interface tetl_rsp_if;
  import tetl_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  logic    hit;
  pad_t    state_one;
  pad_t    state_two;
  count_t  entries;
  modport source (output valid, status, hit, state_one, state_two, entries, input ready);
  modport sink (input valid, status, hit, state_one, state_two, entries, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tetl_store.sv =====
// event table memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module tetl_store (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire tetl_pkg::idx_t   waddr,
  input  wire tetl_pkg::entry_t wdata,
  input  wire tetl_pkg::idx_t   raddr,
  output tetl_pkg::entry_t      rdata
);
  import tetl_pkg::*;

  entry_t mem [MAX_EVENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/timed_event_table_lookup_core.sv =====
// timed event table: append, clear and upper-bound query by binary search
// clear, append and unused codes: the result passes the exec and finish states before it loads
// query: probe and compare states alternate, at most ceil(log2(entries + 1)) probes, up to 9 for 256 entries
// one item at a time: next transfer can be taken in the cycle after the result loads, a held result stalls
// rst clears the entry count, the sequencer and the output valid; table contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
module timed_event_table_lookup_core (
  input wire logic  clk,
  input wire logic  rst,
  tetl_req_if.sink  req,
  tetl_rsp_if.source rsp
);
  import tetl_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_PROBE  = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  op_t        op;
  frame_t     key;
  pad_t       p1;
  pad_t       p2;
  count_t     count;
  frame_t     last_frame;
  count_t     lo;
  count_t     hi;
  count_t     mid;
  count_t     probe_mid;
  status_t    res_status;
  logic       res_hit;
  pad_t       res_one;
  pad_t       res_two;
  logic       out_valid;
  status_t    out_status;
  logic       out_hit;
  pad_t       out_one;
  pad_t       out_two;
  count_t     out_entries;

  logic   is_full;
  logic   bad_order;
  logic   wr_en;
  logic   slot_free;
  logic   out_load;
  entry_t wr_data;
  entry_t rd_data;

  assign is_full   = (count == count_t'(MAX_EVENTS));
  assign bad_order = (count != '0) && (key <= last_frame);
  assign wr_en     = (state == S_EXEC) && (op == OP_APPEND) && !is_full && !bad_order;
  assign wr_data   = '{frame: key, one: p1, two: p2};
  assign probe_mid = lo + ((hi - lo) >> 1);
  assign slot_free = !out_valid || rsp.ready;
  assign out_load  = (state == S_FINISH) && slot_free;

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.hit       = out_hit;
  assign rsp.state_one = out_one;
  assign rsp.state_two = out_two;
  assign rsp.entries   = out_entries;

  tetl_store u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[IDX_W-1:0]),
    .wdata (wr_data),
    .raddr (probe_mid[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.operation;
            key   <= req.frame_number;
            p1    <= req.pad_one;
            p2    <= req.pad_two;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= ST_OK;
          res_hit    <= 1'b0;
          res_one    <= '0;
          res_two    <= '0;
          state      <= S_FINISH;
          case (op)
            OP_CLEAR: begin
              count <= '0;
            end
            OP_APPEND: begin
              if (is_full) begin
                res_status <= ST_FULL;
              end else if (bad_order) begin
                res_status <= ST_ORDER;
              end else begin
                last_frame <= key;
                count      <= count + count_t'(1);
              end
            end
            OP_QUERY: begin
              lo    <= '0;
              hi    <= count;
              state <= S_PROBE;
            end
            default: begin
            end
          endcase
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid   <= probe_mid;
            state <= S_CMP;
          end else begin
            res_hit <= (lo != '0);
            state   <= S_FINISH;
          end
        end
        S_CMP: begin
          // the last probe at or before the key is the entry just below lo
          if (rd_data.frame <= key) begin
            lo      <= mid + count_t'(1);
            res_one <= rd_data.one;
            res_two <= rd_data.two;
          end else begin
            hi <= mid;
          end
          state <= S_PROBE;
        end
        S_FINISH: begin
          if (slot_free) begin
            out_status  <= res_status;
            out_hit     <= res_hit;
            out_one     <= res_hit ? res_one : '0;
            out_two     <= res_hit ? res_two : '0;
            out_entries <= count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
